### rtl/tcpq_pkg.sv
package tcpq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_WIDTH_DEF = 16;
	localparam int ID_PORT_W    = 16;
	localparam int CNT_PORT_W   = 5;

	typedef enum logic [1:0] {
		FN_INSERT     = 2'd0,
		FN_SERVE_PREF = 2'd1,
		FN_SERVE_OLD  = 2'd2,
		FN_WITHDRAW   = 2'd3
	} func_t;

	// Broadcast to every cell for the item being accepted this cycle
	typedef struct packed {
		logic  go;
		func_t func;
		logic  any_pref;
		logic  ins_en;
	} op_t;

	// Passed from each cell to its younger neighbor
	typedef struct packed {
		logic pref_seen;
		logic removing;
	} chain_t;

endpackage

### rtl/tcpq_cell.sv
module tcpq_cell #(
	parameter int ID_W = tcpq_pkg::ID_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tcpq_pkg::op_t    op,
	input  logic [ID_W-1:0]  new_id,
	input  logic             new_pref,
	input  logic             head,
	input  logic             prev_valid,
	input  logic [ID_W-1:0]  up_id,
	input  logic             up_pref,
	input  logic             up_valid,
	input  tcpq_pkg::chain_t chain_in,
	output tcpq_pkg::chain_t chain_out,
	output logic [ID_W-1:0]  id,
	output logic             pref,
	output logic             valid,
	output logic             match,
	output logic             sel
);

	logic [ID_W-1:0] id_q;
	logic            pref_q;
	logic            valid_q;
	logic            sel_pref;
	logic            load_new;

	assign match    = valid_q && (id_q == new_id);
	assign sel_pref = op.any_pref ? (pref_q && !chain_in.pref_seen) : head;

	always_comb begin
		case (op.func)
			tcpq_pkg::FN_SERVE_PREF: sel = op.go && valid_q && sel_pref;
			tcpq_pkg::FN_SERVE_OLD:  sel = op.go && valid_q && head;
			tcpq_pkg::FN_WITHDRAW:   sel = op.go && match;
			default:                 sel = 1'b0;
		endcase
	end

	assign chain_out.pref_seen = chain_in.pref_seen || (valid_q && pref_q);
	assign chain_out.removing  = chain_in.removing || sel;

	// the first empty cell takes a new entry
	assign load_new = op.ins_en && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pref_q  <= 1'b0;
		end else if (chain_out.removing) begin
			valid_q <= up_valid;
			pref_q  <= up_pref;
		end else if (load_new) begin
			valid_q <= 1'b1;
			pref_q  <= new_pref;
		end
	end

	always_ff @(posedge clk) begin
		if (chain_out.removing) begin
			id_q <= up_id;
		end else if (load_new) begin
			id_q <= new_id;
		end
	end

	assign id    = id_q;
	assign pref  = pref_q;
	assign valid = valid_q;

endmodule

### rtl/two_class_priority_queue.sv
// Two-class waiting queue with withdraw. An item is accepted on any clock
// edge where start is high and busy is low; busy stays low, so a new item may
// be issued every cycle. Exactly one result follows each item, on the cycle
// right after it is accepted, marked by done for that single cycle; the
// receiver cannot stall it, so capture ok, served_id and the counts then.
// Entries sit in a row of DEPTH cells in arrival order, oldest in cell 0.
// Insert rejects a duplicate id or a full row. Serve-preferred removes the
// oldest preferred entry (or the oldest entry if none is preferred),
// serve-oldest removes cell 0, withdraw removes the matching id. Every cell
// compares and shifts in the same cycle; the result is registered, and the
// compare-and-shift path through the cell row sets the clock period.
// The row is empty after reset; no clearing pass is needed.
module two_class_priority_queue #(
	parameter int DEPTH    = tcpq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = tcpq_pkg::ID_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        func,
	input  logic [tcpq_pkg::ID_PORT_W-1:0]    person_id,
	input  logic                              is_preferred,
	output logic                              done,
	output logic                              ok,
	output logic [tcpq_pkg::ID_PORT_W-1:0]    served_id,
	output logic [tcpq_pkg::CNT_PORT_W-1:0]   total_count,
	output logic [tcpq_pkg::CNT_PORT_W-1:0]   preferred_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                 accept;
	tcpq_pkg::func_t      fn;
	tcpq_pkg::op_t        op;
	logic [ID_WIDTH-1:0]  key;

	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     pref_cnt_q;
	logic [CNT_W-1:0]     total_nxt;
	logic [CNT_W-1:0]     pref_nxt;

	logic [ID_WIDTH-1:0]  cell_id   [DEPTH+1];
	logic [DEPTH:0]       cell_pref;
	logic [DEPTH:0]       cell_valid;
	tcpq_pkg::chain_t     chain     [DEPTH+1];
	logic [DEPTH-1:0]     cell_match;
	logic [DEPTH-1:0]     cell_sel;

	logic                 full;
	logic                 dup;
	logic                 ok_nxt;
	logic                 rm_pref;
	logic [ID_WIDTH-1:0]  rm_id;

	// Every item is handled as it is accepted, so never hold off the issuer
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign fn     = tcpq_pkg::func_t'(func);
	assign key    = ID_WIDTH'(person_id);

	assign full = (total_q == CNT_W'(DEPTH));
	assign dup  = |cell_match;

	assign op.go       = accept;
	assign op.func     = fn;
	assign op.any_pref = (pref_cnt_q != '0);
	assign op.ins_en   = accept && (fn == tcpq_pkg::FN_INSERT) && !full && !dup;

	// Sentinel above the youngest cell: shifts pull in an empty entry
	assign cell_id[DEPTH]    = '0;
	assign cell_pref[DEPTH]  = 1'b0;
	assign cell_valid[DEPTH] = 1'b0;
	assign chain[0]          = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic pv;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
		end else begin : g_body
			assign pv = cell_valid[i-1];
		end

		tcpq_cell #(
			.ID_W (ID_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.new_id     (key),
			.new_pref   (is_preferred),
			.head       (i == 0),
			.prev_valid (pv),
			.up_id      (cell_id[i+1]),
			.up_pref    (cell_pref[i+1]),
			.up_valid   (cell_valid[i+1]),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.id         (cell_id[i]),
			.pref       (cell_pref[i]),
			.valid      (cell_valid[i]),
			.match      (cell_match[i]),
			.sel        (cell_sel[i])
		);
	end

	// Gather the id and mark of the removed cell (at most one is selected)
	always_comb begin
		rm_id   = '0;
		rm_pref = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_sel[i]) begin
				rm_id   = rm_id | cell_id[i];
				rm_pref = rm_pref | cell_pref[i];
			end
		end
	end

	// Track counts alongside the row rather than summing valid bits
	always_comb begin
		total_nxt = total_q;
		pref_nxt  = pref_cnt_q;
		ok_nxt    = 1'b0;
		case (fn)
			tcpq_pkg::FN_INSERT: begin
				ok_nxt = op.ins_en;
				if (op.ins_en) begin
					total_nxt = total_q + CNT_W'(1);
					pref_nxt  = pref_cnt_q + CNT_W'(is_preferred);
				end
			end
			tcpq_pkg::FN_SERVE_PREF, tcpq_pkg::FN_SERVE_OLD, tcpq_pkg::FN_WITHDRAW: begin
				ok_nxt = |cell_sel;
				if (|cell_sel) begin
					total_nxt = total_q - CNT_W'(1);
					pref_nxt  = pref_cnt_q - CNT_W'(rm_pref);
				end
			end
			default: ok_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			pref_cnt_q <= '0;
			done       <= 1'b0;
		end else begin
			done <= accept;
			if (accept) begin
				total_q    <= total_nxt;
				pref_cnt_q <= pref_nxt;
			end
		end
	end

	// Result payload: hold until the next item
	always_ff @(posedge clk) begin
		if (accept) begin
			ok              <= ok_nxt;
			served_id       <= ((fn == tcpq_pkg::FN_SERVE_PREF || fn == tcpq_pkg::FN_SERVE_OLD)
			                    && ok_nxt) ? tcpq_pkg::ID_PORT_W'(rm_id) : '0;
			total_count     <= tcpq_pkg::CNT_PORT_W'(total_nxt);
			preferred_count <= tcpq_pkg::CNT_PORT_W'(pref_nxt);
		end
	end

	// Row stays packed toward cell 0
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid[DEPTH-1:0] & (cell_valid[DEPTH-1:0] + 1'b1)) == '0))
		else $error("valid cells not packed toward the head");

	// Running total agrees with the valid cells
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(total_q) == 32'($countones(cell_valid[DEPTH-1:0]))))
		else $error("total count out of step with cell row");

	// Running preferred count agrees with the row
	a_pref: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pref_cnt_q) ==
		 32'($countones(cell_valid[DEPTH-1:0] & cell_pref[DEPTH-1:0]))))
		else $error("preferred count out of step with cell row");

	// A result only follows an accepted item
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result strobe without an accepted item");

endmodule

### tb/sv/tb_two_class_priority_queue.sv
class waitlist_scoreboard;

	typedef struct {
		logic                             ok;
		logic [tcpq_pkg::ID_PORT_W-1:0]   served_id;
		logic [tcpq_pkg::CNT_PORT_W-1:0]  total_count;
		logic [tcpq_pkg::CNT_PORT_W-1:0]  preferred_count;
	} outcome_t;

	localparam int DEPTH = tcpq_pkg::DEPTH_DEF;
	localparam logic [tcpq_pkg::ID_PORT_W-1:0] ID_MASK = (1 << tcpq_pkg::ID_WIDTH_DEF) - 1;

	// Waiting line, oldest first
	logic [tcpq_pkg::ID_PORT_W-1:0] line_id[$];
	bit                             line_pref[$];
	outcome_t                       pending_outcomes[$];
	int                             errors;

	function int waiting();
		return line_id.size();
	endfunction

	function logic [tcpq_pkg::ID_PORT_W-1:0] waiting_id(int k);
		return line_id[k];
	endfunction

	function int outstanding();
		return pending_outcomes.size();
	endfunction

	function int find_waiting(logic [tcpq_pkg::ID_PORT_W-1:0] id);
		foreach (line_id[i])
			if (line_id[i] == id)
				return i;
		return -1;
	endfunction

	// Apply one accepted item to the line and queue the outcome it must produce
	function void note_item(tcpq_pkg::func_t f, logic [tcpq_pkg::ID_PORT_W-1:0] raw_id,
	                        logic pref);
		outcome_t                       o;
		logic [tcpq_pkg::ID_PORT_W-1:0] id;
		int                             k;
		int                             npref;
		id = raw_id & ID_MASK;
		o.ok = 1'b0;
		o.served_id = '0;
		case (f)
			tcpq_pkg::FN_INSERT: begin
				if (line_id.size() < DEPTH && find_waiting(id) < 0) begin
					line_id.push_back(id);
					line_pref.push_back(pref);
					o.ok = 1'b1;
				end
			end
			tcpq_pkg::FN_SERVE_PREF, tcpq_pkg::FN_SERVE_OLD: begin
				if (line_id.size() > 0) begin
					k = 0;
					if (f == tcpq_pkg::FN_SERVE_PREF) begin
						foreach (line_pref[i])
							if (line_pref[i]) begin
								k = i;
								break;
							end
					end
					o.served_id = line_id[k];
					line_id.delete(k);
					line_pref.delete(k);
					o.ok = 1'b1;
				end
			end
			default: begin
				k = find_waiting(id);
				if (k >= 0) begin
					line_id.delete(k);
					line_pref.delete(k);
					o.ok = 1'b1;
				end
			end
		endcase
		npref = 0;
		foreach (line_pref[i])
			npref += line_pref[i];
		o.total_count = line_id.size();
		o.preferred_count = npref;
		pending_outcomes.push_back(o);
	endfunction

	function void check_result(logic ok, logic [tcpq_pkg::ID_PORT_W-1:0] served_id,
	                           logic [tcpq_pkg::CNT_PORT_W-1:0] total_count,
	                           logic [tcpq_pkg::CNT_PORT_W-1:0] preferred_count);
		outcome_t o;
		if (pending_outcomes.size() == 0) begin
			$error("result with no item outstanding");
			errors++;
			return;
		end
		o = pending_outcomes.pop_front();
		if (ok !== o.ok) begin
			$error("ok: expected %0d, got %0d", o.ok, ok);
			errors++;
		end
		if (served_id !== o.served_id) begin
			$error("served_id: expected %h, got %h", o.served_id, served_id);
			errors++;
		end
		if (total_count !== o.total_count) begin
			$error("total_count: expected %0d, got %0d", o.total_count, total_count);
			errors++;
		end
		if (preferred_count !== o.preferred_count) begin
			$error("preferred_count: expected %0d, got %0d", o.preferred_count,
			       preferred_count);
			errors++;
		end
	endfunction

endclass

module tb_two_class_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int QUIET_LIMIT = 200;   // well above the longest sender gap
	localparam int RANDOM_ITEMS = 500;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	func_t                   func;
	logic [ID_PORT_W-1:0]    person_id;
	logic                    is_preferred;
	logic                    done;
	logic                    ok;
	logic [ID_PORT_W-1:0]    served_id;
	logic [CNT_PORT_W-1:0]   total_count;
	logic [CNT_PORT_W-1:0]   preferred_count;

	waitlist_scoreboard sb = new();

	// Percentage of items preceded by a sender gap in the current phase
	int idle_pct;
	int quiet_cycles;
	logic [ID_PORT_W-1:0] id_pool[24];

	two_class_priority_queue dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.person_id       (person_id),
		.is_preferred    (is_preferred),
		.done            (done),
		.ok              (ok),
		.served_id       (served_id),
		.total_count     (total_count),
		.preferred_count (preferred_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample at the rising edge: record each accepted item first, then check the
	// strobed result against the oldest outstanding outcome. Both reads see the
	// values from before the edge, so the order against the block's own update
	// does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(func, person_id, is_preferred);
			if (done)
				sb.check_result(ok, served_id, total_count, preferred_count);
			// Watchdog: count cycles in which neither an item nor a result moves
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_two_class_priority_queue: errors");
				$finish;
			end
		end
	end

	// Present one item from the falling edge and hold it until accepted.
	// An optional gap of idle cycles goes first, with start low.
	task automatic send_item(func_t f, logic [ID_PORT_W-1:0] id, logic pref);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			func <= func_t'($urandom_range(3));
			person_id <= $urandom();
			is_preferred <= $urandom_range(1);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		func <= f;
		person_id <= id;
		is_preferred <= pref;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Mostly ids from a small pool, so duplicates and withdraw hits are common
	function automatic logic [ID_PORT_W-1:0] pick_id();
		if ($urandom_range(99) < 75)
			return id_pool[$urandom_range(23)];
		return $urandom();
	endfunction

	// One random item; insert_pct steers the line toward full or toward empty
	task automatic random_item(int insert_pct);
		func_t                f;
		logic [ID_PORT_W-1:0] id;
		int                   r;
		r = $urandom_range(99);
		if (r < insert_pct)
			f = FN_INSERT;
		else
			case ($urandom_range(2))
				0: f = FN_SERVE_PREF;
				1: f = FN_SERVE_OLD;
				default: f = FN_WITHDRAW;
			endcase
		if (f == FN_SERVE_PREF || f == FN_SERVE_OLD)
			id = $urandom();   // ignored by serves, keep it noisy
		else if (sb.waiting() > 0 && $urandom_range(99) < ((f == FN_WITHDRAW) ? 65 : 15))
			id = sb.waiting_id($urandom_range(sb.waiting() - 1));
		else
			id = pick_id();
		send_item(f, id, $urandom_range(1));
	endtask

	initial begin
		int phase;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_INSERT;
		person_id = '0;
		is_preferred = 1'b0;
		quiet_cycles = 0;
		idle_pct = 0;
		foreach (id_pool[i])
			id_pool[i] = $urandom();
		id_pool[0] = '0;
		id_pool[1] = '1;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: each serve and the withdraw on an empty line
		send_item(FN_WITHDRAW, 16'h1234, 1'b0);
		send_item(FN_SERVE_PREF, 16'hFFFF, 1'b1);
		send_item(FN_SERVE_OLD, 16'h0000, 1'b0);
		// Extreme ids, then a duplicate insert
		send_item(FN_INSERT, 16'h0000, 1'b0);
		send_item(FN_INSERT, 16'hFFFF, 1'b1);
		send_item(FN_INSERT, 16'hFFFF, 1'b0);
		// Fill the line, then one insert too many
		for (int i = 0; i < DEPTH - 2; i++)
			send_item(FN_INSERT, 16'h0100 + i, i[0]);
		send_item(FN_INSERT, 16'h5A5A, 1'b1);
		// Serve from the middle and from the head, withdraw a hit and a miss
		send_item(FN_SERVE_PREF, 16'h0000, 1'b0);
		send_item(FN_SERVE_OLD, 16'h0000, 1'b0);
		send_item(FN_WITHDRAW, 16'h0105, 1'b0);
		send_item(FN_WITHDRAW, 16'h0105, 1'b1);

		// Random: three idling phases, each swinging between fill and drain
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 54;
				default: idle_pct = 20;
			endcase
			for (n = 0; n < RANDOM_ITEMS / 3; n++)
				random_item(((n / 40) % 2 == 0) ? 65 : 20);
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain outstanding results, then watch for stray strobes
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.errors == 0)
			$display("tb_two_class_priority_queue: clean");
		else
			$display("tb_two_class_priority_queue: errors");
		$finish;
	end

endmodule
